// File: design/dna_kmer_counter_unit_assert.svh
// Assertion macros used by the k-mer counter back end (dkc_back).
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef DNA_KMER_COUNTER_UNIT_ASSERT_SVH
`define DNA_KMER_COUNTER_UNIT_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define DKC_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as its antecedent.
`define DKC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after its antecedent.
`define DKC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/dkc_pkg.sv
package dkc_pkg;

  localparam int MAX_WORD_LENGTH = 8;
  localparam int WL_W = 4;
  localparam int RUN_W = $clog2(MAX_WORD_LENGTH + 1);
  localparam int WINDOW_W = 2 * MAX_WORD_LENGTH;
  localparam int TABLE_DEPTH = 1 << WINDOW_W;
  localparam int COUNT_W = 32;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [WINDOW_W-1:0] TABLE_LAST = {WINDOW_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [1:0] ACT_BASE = 2'd0;
  localparam logic [1:0] ACT_LINE = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [WL_W-1:0] WORD_LENGTH_RESET = 4'd8;

  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_C_UP = 8'h43;
  localparam logic [7:0] CH_G_UP = 8'h47;
  localparam logic [7:0] CH_T_UP = 8'h54;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_C_LO = 8'h63;
  localparam logic [7:0] CH_G_LO = 8'h67;
  localparam logic [7:0] CH_T_LO = 8'h74;

  // One table operation handed from the front end to the back end.
  typedef struct packed {
    logic kind;
    logic [WINDOW_W-1:0] index;
  } op_t;

  function automatic logic [WL_W-1:0] eff_length(input logic [WL_W-1:0] wl);
    logic [WL_W-1:0] k;
    k = wl;
    if (k == '0) begin
      k = WL_W'(1);
    end else if (k > WL_W'(MAX_WORD_LENGTH)) begin
      k = WL_W'(MAX_WORD_LENGTH);
    end
    return k;
  endfunction

  function automatic logic [WINDOW_W-1:0] window_mask(input logic [WL_W-1:0] k);
    return ~({WINDOW_W{1'b1}} << {k, 1'b0});
  endfunction

  function automatic logic [1:0] base_value(input logic [7:0] ch);
    logic [1:0] v;
    case (ch)
      CH_C_UP, CH_C_LO: v = 2'd1;
      CH_G_UP, CH_G_LO: v = 2'd2;
      CH_T_UP, CH_T_LO: v = 2'd3;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/dna_kmer_counter_unit.sv
// Streaming k-mer counter. One character, line start or count query is taken per cycle
// when the output side keeps up; the front end tracks the window of 2-bit bases and the
// run of valid bases, and a four-entry queue feeds the back end, which does a
// read-modify-write on the 65536-entry count table with forwarding from the last write,
// so repeated k-mers in consecutive cycles still sustain one item per cycle. A counted
// k-mer or a query result passes through the queue, the read stage and the output
// register in turn. After reset the back end clears the table, one entry per cycle, and
// in_ready stays low until it is done; word_length writes are accepted throughout.
module dna_kmer_counter_unit
  import dkc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [WL_W-1:0]     cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic [7:0]          symbol,
  input  logic [WINDOW_W-1:0] carried_window,
  input  logic [WINDOW_W-1:0] query_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                kind,
  output logic [WINDOW_W-1:0] kmer_index,
  output logic [COUNT_W-1:0]  count
);

  logic clearing;
  logic q_ready;
  logic push;
  op_t push_op;
  logic pop;
  logic head_valid;
  op_t head_op;

  dkc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .symbol         (symbol),
    .carried_window (carried_window),
    .query_index    (query_index),
    .clearing       (clearing),
    .q_ready        (q_ready),
    .push           (push),
    .push_op        (push_op)
  );

  dkc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .push_ready (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  dkc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .clearing   (clearing),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_kind   (kind),
    .out_index  (kmer_index),
    .out_count  (count)
  );

endmodule

// File: design/dkc_fifo.sv
module dkc_fifo
  import dkc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic push_ready,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  op_t entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] fill;

  assign push_ready = (fill != FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid = (fill != '0);
  assign head_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

// File: design/dkc_front.sv
module dkc_front
  import dkc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [WL_W-1:0]     cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic [7:0]          symbol,
  input  logic [WINDOW_W-1:0] carried_window,
  input  logic [WINDOW_W-1:0] query_index,
  input  logic                clearing,
  input  logic                q_ready,
  output logic                push,
  output op_t                 push_op
);

  logic [WL_W-1:0] word_length;
  logic [WINDOW_W-1:0] window;
  logic [WINDOW_W-1:0] window_next;
  logic [RUN_W-1:0] run_length;
  logic [RUN_W-1:0] run_length_next;
  logic [WL_W-1:0] k;
  logic [WINDOW_W-1:0] mask;
  logic accept;
  logic want_push;

  assign k = eff_length(word_length);
  assign mask = window_mask(k);
  assign in_ready = !clearing && q_ready;
  assign accept = in_valid && in_ready;
  assign push = accept && want_push;

  always_comb begin
    window_next = window;
    run_length_next = run_length;
    want_push = 1'b0;
    push_op.kind = KIND_COUNT;
    push_op.index = '0;
    case (action)
      ACT_BASE: begin
        if (symbol inside {CH_A_UP, CH_C_UP, CH_G_UP, CH_T_UP,
                           CH_A_LO, CH_C_LO, CH_G_LO, CH_T_LO}) begin
          window_next = {window[WINDOW_W-3:0], base_value(symbol)} & mask;
          if (run_length < RUN_W'(MAX_WORD_LENGTH)) begin
            run_length_next = run_length + RUN_W'(1);
          end
          want_push = (WL_W'(run_length_next) >= k);
          push_op.kind = KIND_COUNT;
          push_op.index = window_next;
        end else begin
          run_length_next = '0;
        end
      end
      ACT_LINE: begin
        window_next = carried_window & mask;
        run_length_next = RUN_W'(k);
      end
      ACT_READ: begin
        want_push = 1'b1;
        push_op.kind = KIND_READ;
        push_op.index = query_index;
      end
      default: begin
        want_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length <= WORD_LENGTH_RESET;
      window <= '0;
      run_length <= '0;
    end else begin
      if (cfg_we) begin
        word_length <= cfg_wdata;
      end
      if (accept) begin
        window <= window_next;
        run_length <= run_length_next;
      end
    end
  end

endmodule

// File: design/dkc_back.sv
`include "dna_kmer_counter_unit_assert.svh"

module dkc_back
  import dkc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  output logic                clearing,
  input  logic                head_valid,
  input  op_t                 head_op,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic [WINDOW_W-1:0] out_index,
  output logic [COUNT_W-1:0]  out_count
);

  logic [COUNT_W-1:0] counts [TABLE_DEPTH];
  logic [WINDOW_W-1:0] clr_idx;
  logic s1_valid;
  op_t s1_op;
  logic s1_fire;
  logic [COUNT_W-1:0] rdata;
  logic fwd_valid;
  logic [WINDOW_W-1:0] fwd_idx;
  logic [COUNT_W-1:0] fwd_val;
  logic [COUNT_W-1:0] cur;
  logic [COUNT_W-1:0] incr;
  logic wr_en;

  assign s1_fire = s1_valid && (!out_valid || out_ready);
  assign pop = head_valid && !clearing && (!s1_valid || s1_fire);

  // The most recent write is newer than anything the table read may have returned.
  assign cur = (fwd_valid && (fwd_idx == s1_op.index)) ? fwd_val : rdata;
  assign incr = (cur == COUNT_MAX) ? cur : cur + COUNT_W'(1);
  assign wr_en = s1_fire && (s1_op.kind == KIND_COUNT);

  always_ff @(posedge clk) begin
    if (clearing) begin
      counts[clr_idx] <= '0;
    end else if (wr_en) begin
      counts[s1_op.index] <= incr;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rdata <= counts[head_op.index];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op <= head_op;
    end
    if (wr_en) begin
      fwd_idx <= s1_op.index;
      fwd_val <= incr;
    end
    if (s1_fire) begin
      out_kind <= s1_op.kind;
      out_index <= s1_op.index;
      out_count <= (s1_op.kind == KIND_COUNT) ? incr : cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx <= '0;
      s1_valid <= 1'b0;
      fwd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + WINDOW_W'(1);
        if (clr_idx == TABLE_LAST) begin
          clearing <= 1'b0;
        end
      end
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (wr_en) begin
        fwd_valid <= 1'b1;
      end
      if (s1_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `DKC_ASSERT_IMP(a_idle_in_clear, clearing, !s1_valid && !pop, "work issued during clear")
  `DKC_ASSERT_NEXT(a_pop_loads_stage, pop, s1_valid, "popped operation lost")
  `DKC_ASSERT_IMP(a_count_nonzero, out_valid && (out_kind == KIND_COUNT), out_count != 0, "zero count")
  `DKC_ASSERT_IMP(a_clear_complete, $fell(clearing), $past(clr_idx) == TABLE_LAST, "short clear")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import dkc_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 400000;
  localparam int HOLD_CYCLES = 100;
  localparam int HOLD_AFTER = 150;
  localparam int PHASE_ITEMS = 62;

  typedef struct {
    logic [1:0]          act;
    logic [7:0]          sym;
    logic [WINDOW_W-1:0] carry;
    logic [WINDOW_W-1:0] query;
  } dna_item_t;

  typedef struct {
    logic                kind;
    logic [WINDOW_W-1:0] idx;
    logic [COUNT_W-1:0]  cnt;
  } tally_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [WL_W-1:0]     cfg_wdata = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          action = ACT_BASE;
  logic [7:0]          symbol = '0;
  logic [WINDOW_W-1:0] carried_window = '0;
  logic [WINDOW_W-1:0] query_index = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                kind;
  logic [WINDOW_W-1:0] kmer_index;
  logic [COUNT_W-1:0]  count;

  logic [7:0] base_chars [8] = '{CH_A_UP, CH_C_UP, CH_G_UP, CH_T_UP,
                                 CH_A_LO, CH_C_LO, CH_G_LO, CH_T_LO};
  logic [WL_W-1:0] wl_plan [7] = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd9, 4'd5};

  dna_item_t stim_q[$];
  tally_t awaited_tallies[$];
  dna_item_t next_item;
  dna_item_t taken_item;
  tally_t want;

  // Shadow state of the counter.
  bit [COUNT_W-1:0]    model_table [TABLE_DEPTH];
  logic [WINDOW_W-1:0] model_window = '0;
  int                  model_run = 0;
  logic [WL_W-1:0]     model_wl = WORD_LENGTH_RESET;

  int  items_queued = 0;
  int  inputs_taken = 0;
  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  held_once = 1'b0;
  bit  calm = 1'b0;

  dna_kmer_counter_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .action         (action),
    .symbol         (symbol),
    .carried_window (carried_window),
    .query_index    (query_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .kmer_index     (kmer_index),
    .count          (count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void enqueue(input logic [1:0] act, input logic [7:0] sym,
                                  input logic [WINDOW_W-1:0] carry,
                                  input logic [WINDOW_W-1:0] query);
    dna_item_t it;
    it.act = act;
    it.sym = sym;
    it.carry = carry;
    it.query = query;
    stim_q = {stim_q, it};
    items_queued++;
  endfunction

  // Updates the shadow state for one accepted item and records the tally it causes.
  function automatic void tally_item(input dna_item_t it);
    logic [WL_W-1:0]     k;
    logic [WINDOW_W-1:0] mask;
    logic [1:0]          bval;
    bit                  is_base;
    tally_t              res;
    k = model_wl;
    if (k == '0) begin
      k = WL_W'(1);
    end else if (k > WL_W'(MAX_WORD_LENGTH)) begin
      k = WL_W'(MAX_WORD_LENGTH);
    end
    mask = WINDOW_W'((33'd1 << (2 * k)) - 33'd1);
    case (it.act)
      ACT_BASE: begin
        is_base = 1'b1;
        bval = 2'd0;
        case (it.sym)
          CH_A_UP, CH_A_LO: bval = 2'd0;
          CH_C_UP, CH_C_LO: bval = 2'd1;
          CH_G_UP, CH_G_LO: bval = 2'd2;
          CH_T_UP, CH_T_LO: bval = 2'd3;
          default: is_base = 1'b0;
        endcase
        if (!is_base) begin
          model_run = 0;
        end else begin
          model_window = ((model_window << 2) | WINDOW_W'(bval)) & mask;
          if (model_run < MAX_WORD_LENGTH) begin
            model_run++;
          end
          if (model_run >= k) begin
            if (model_table[model_window] != COUNT_MAX) begin
              model_table[model_window]++;
            end
            res.kind = KIND_COUNT;
            res.idx = model_window;
            res.cnt = model_table[model_window];
            awaited_tallies = {awaited_tallies, res};
          end
        end
      end
      ACT_LINE: begin
        model_window = it.carry & mask;
        model_run = k;
      end
      ACT_READ: begin
        res.kind = KIND_READ;
        res.idx = it.query;
        res.cnt = model_table[it.query];
        awaited_tallies = {awaited_tallies, res};
      end
      default: ;
    endcase
  endfunction

  function automatic void log_mismatch(input string field, input logic [COUNT_W-1:0] exp_v,
                                       input logic [COUNT_W-1:0] act_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, exp_v, act_v);
    end
  endfunction

  task automatic wait_drained();
    while (inputs_taken != items_queued || awaited_tallies.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Sender: a new item goes out once the previous one has been transferred.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (stim_q.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
        next_item = stim_q.pop_front();
        in_valid <= 1'b1;
        action <= next_item.act;
        symbol <= next_item.sym;
        carried_window <= next_item.carry;
        query_index <= next_item.query;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so that the block backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (!held_once && inputs_taken >= HOLD_AFTER) begin
      held_once <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= (hold_left == 1);
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (awaited_tallies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with nothing awaited: kind %0d index %0h count %0h",
                     $time, kind, kmer_index, count);
          end
        end else begin
          want = awaited_tallies.pop_front();
          if (kind !== want.kind) log_mismatch("kind", COUNT_W'(want.kind), COUNT_W'(kind));
          if (kmer_index !== want.idx) begin
            log_mismatch("kmer_index", COUNT_W'(want.idx), COUNT_W'(kmer_index));
          end
          if (count !== want.cnt) log_mismatch("count", want.cnt, count);
        end
      end
      if (in_valid && in_ready) begin
        taken_item.act = action;
        taken_item.sym = symbol;
        taken_item.carry = carried_window;
        taken_item.query = query_index;
        tally_item(taken_item);
        inputs_taken <= inputs_taken + 1;
      end
    end
  end

  // The table clear after reset keeps the input stalled for a long time, hence the limit.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase;
    int r;
    int bval;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset word length of eight.
    enqueue(ACT_BASE, CH_A_UP, '0, '0);
    enqueue(ACT_BASE, CH_C_LO, '0, '0);
    enqueue(ACT_BASE, CH_G_UP, '0, '0);
    enqueue(ACT_BASE, CH_T_LO, '0, '0);
    enqueue(ACT_BASE, CH_A_LO, '0, '0);
    enqueue(ACT_BASE, CH_C_UP, '0, '0);
    enqueue(ACT_BASE, CH_G_LO, '0, '0);
    enqueue(ACT_BASE, CH_T_UP, '0, '0);
    enqueue(ACT_BASE, CH_A_UP, '0, '0);
    enqueue(ACT_BASE, 8'h4E, '0, '0);
    enqueue(ACT_LINE, '0, TABLE_LAST, '0);
    enqueue(ACT_BASE, CH_T_LO, '0, '0);
    enqueue(ACT_LINE, '0, '0, '0);
    enqueue(ACT_BASE, CH_A_LO, '0, '0);
    enqueue(ACT_LINE, '0, '0, '0);
    enqueue(ACT_BASE, CH_A_UP, '0, '0);
    enqueue(ACT_READ, '0, '0, '0);
    enqueue(ACT_READ, '0, '0, TABLE_LAST);
    enqueue(ACT_READ, '0, '0, 16'h1234);
    enqueue(ACT_UNUSED, 8'hFF, TABLE_LAST, TABLE_LAST);
    enqueue(ACT_BASE, 8'h00, '0, '0);
    enqueue(ACT_BASE, 8'hFF, '0, '0);
    enqueue(ACT_BASE, CH_G_LO, '0, '0);
    enqueue(ACT_READ, '0, '0, 16'h1B1B);

    for (phase = 0; phase < 7; phase++) begin
      wait_drained();
      repeat (8) @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= wl_plan[phase];
      @(posedge clk);
      cfg_we <= 1'b0;
      model_wl = wl_plan[phase];
      calm = (phase == 3);
      // Mostly runs of bases from a narrow alphabet so that counts climb.
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 72) begin
          bval = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 1);
          enqueue(ACT_BASE, base_chars[bval + 4 * $urandom_range(0, 1)],
                  WINDOW_W'($urandom), WINDOW_W'($urandom));
        end else if (r < 80) begin
          enqueue(ACT_LINE, 8'($urandom), WINDOW_W'($urandom), WINDOW_W'($urandom));
        end else if (r < 92) begin
          enqueue(ACT_READ, 8'($urandom), WINDOW_W'($urandom),
                  ($urandom_range(0, 1) == 0) ? WINDOW_W'($urandom)
                                              : WINDOW_W'($urandom_range(0, 255)));
        end else if (r < 98) begin
          enqueue(ACT_BASE, 8'($urandom_range(0, 255)), WINDOW_W'($urandom),
                  WINDOW_W'($urandom));
        end else begin
          enqueue(ACT_UNUSED, 8'($urandom), WINDOW_W'($urandom), WINDOW_W'($urandom));
        end
      end
    end

    wait_drained();
    calm = 1'b0;
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited_tallies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/dkc_pkg.sv
design/dkc_fifo.sv
design/dkc_front.sv
design/dkc_back.sv
design/dna_kmer_counter_unit.sv
verif/tb_top.sv
